// File: rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Types and widths shared by the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int CoordWidth     = 16;
  localparam int EdgeWidth      = CoordWidth + 1;
  localparam int ProdWidth      = 2 * EdgeWidth;
  localparam int CrossWidth     = ProdWidth + 1;
  localparam int SqWidth        = 2 * CrossWidth;
  localparam int RootWidth      = CrossWidth + 1;
  localparam int SumWidth       = 2 * RootWidth;
  localparam int OutWidth       = 16;
  localparam int NormalFracBits = 14;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [OutWidth-1:0]   comp_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } tri_in_t;

  typedef struct packed {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degenerate;
  } tri_out_t;

endpackage

// File: rtl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle: cross product of the edges from vertex a
// to b and to c, divided by its floor integer square root length.
// ----------------------------------------------------------------------------
// One item is accepted per cycle unless the output stalls; the depth is set by
// the square root, which resolves one root bit per stage, and the division,
// one quotient bit per stage. The whole pipeline holds while a finished item
// waits at the output.
// Reset clears the valid bits only.
module triangle_unit_normal
  import tun_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = NormalFracBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tri_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tri_out_t out_data_o
);

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int QW = F + 1;
  localparam int XW = ((QW > OutWidth) ? QW : OutWidth) + 1;
  localparam int RW = RootWidth;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Edges.
  logic signed [EdgeWidth-1:0] e_q [3];
  logic signed [EdgeWidth-1:0] f_q [3];
  logic v1_q;
  // Products.
  logic signed [ProdWidth-1:0] p_q [6];
  logic v2_q;
  // Cross product.
  logic signed [CrossWidth-1:0] n3_q [3];
  logic v3_q;
  // Squares.
  logic [SqWidth-1:0] sq_q [3];
  logic signed [CrossWidth-1:0] n4_q [3];
  logic v4_q;

  // Square root pipeline, index 0 is fed by the sum stage.
  logic [SumWidth-1:0]          rad_q  [RW+1];
  logic [RW+1:0]                rem_q  [RW+1];
  logic [RW-1:0]                root_q [RW+1];
  logic signed [CrossWidth-1:0] ns_q   [RW+1][3];
  logic                         dg_q   [RW+1];
  logic                         vs_q   [RW+1];

  // Division pipeline, index 0 is fed by the magnitude stage.
  logic [RW-1:0]       len_q [QW+1];
  logic [RW-1:0]       r_q   [QW+1][3];
  logic [QW-1:0]       qt_q  [QW+1][3];
  logic                ng_q  [QW+1][3];
  logic                dd_q  [QW+1];
  logic                vd_q  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vs_q[0] <= 1'b0;
      vd_q[0] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vs_q[0] <= v4_q;
      vd_q[0] <= vs_q[RW];
      out_valid_o <= vd_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= EdgeWidth'(in_data_i.bx) - EdgeWidth'(in_data_i.ax);
      e_q[1] <= EdgeWidth'(in_data_i.by_) - EdgeWidth'(in_data_i.ay);
      e_q[2] <= EdgeWidth'(in_data_i.bz) - EdgeWidth'(in_data_i.az);
      f_q[0] <= EdgeWidth'(in_data_i.cx) - EdgeWidth'(in_data_i.ax);
      f_q[1] <= EdgeWidth'(in_data_i.cy) - EdgeWidth'(in_data_i.ay);
      f_q[2] <= EdgeWidth'(in_data_i.cz) - EdgeWidth'(in_data_i.az);

      p_q[0] <= e_q[1] * f_q[2];
      p_q[1] <= e_q[2] * f_q[1];
      p_q[2] <= e_q[2] * f_q[0];
      p_q[3] <= e_q[0] * f_q[2];
      p_q[4] <= e_q[0] * f_q[1];
      p_q[5] <= e_q[1] * f_q[0];

      n3_q[0] <= CrossWidth'(p_q[0]) - CrossWidth'(p_q[1]);
      n3_q[1] <= CrossWidth'(p_q[2]) - CrossWidth'(p_q[3]);
      n3_q[2] <= CrossWidth'(p_q[4]) - CrossWidth'(p_q[5]);

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SqWidth'(n3_q[i] * n3_q[i]);
        n4_q[i] <= n3_q[i];
      end

      rad_q[0]  <= SumWidth'(sq_q[0]) + SumWidth'(sq_q[1]) + SumWidth'(sq_q[2]);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      dg_q[0]   <= (sq_q[0] == '0) && (sq_q[1] == '0) && (sq_q[2] == '0);
      for (int i = 0; i < 3; i++) ns_q[0][i] <= n4_q[i];

      len_q[0] <= root_q[RW];
      dd_q[0]  <= dg_q[RW];
      for (int i = 0; i < 3; i++) begin
        ng_q[0][i] <= ns_q[RW][i][CrossWidth-1];
        r_q[0][i]  <= ns_q[RW][i][CrossWidth-1] ? RW'(-ns_q[RW][i]) : RW'(ns_q[RW][i]);
        qt_q[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    assign rem_sh = {rem_q[k][RW-1:0], rad_q[k][SumWidth-1 -: 2]};
    assign trial  = {root_q[k], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (en) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k+1] <= {rad_q[k][SumWidth-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[k+1]  <= rem_sh - trial;
          root_q[k+1] <= {root_q[k][RW-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= rem_sh;
          root_q[k+1] <= {root_q[k][RW-2:0], 1'b0};
        end
        dg_q[k+1] <= dg_q[k];
        for (int i = 0; i < 3; i++) ns_q[k+1][i] <= ns_q[k][i];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW:0] t [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = (j == 0) ? {1'b0, r_q[j][i]} : {r_q[j][i], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else if (en) begin
        vd_q[j+1] <= vd_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        len_q[j+1] <= len_q[j];
        dd_q[j+1]  <= dd_q[j];
        for (int i = 0; i < 3; i++) begin
          ng_q[j+1][i] <= ng_q[j][i];
          if (t[i] >= {1'b0, len_q[j]}) begin
            r_q[j+1][i]  <= RW'(t[i] - {1'b0, len_q[j]});
            qt_q[j+1][i] <= {qt_q[j][i][QW-2:0], 1'b1};
          end else begin
            r_q[j+1][i]  <= RW'(t[i]);
            qt_q[j+1][i] <= {qt_q[j][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [XW-1:0] qx [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = XW'(qt_q[QW][i]);
      if (ng_q[QW][i]) qx[i] = -qx[i];
      if (dd_q[QW]) qx[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.nx         <= qx[0][OutWidth-1:0];
      out_data_o.ny         <= qx[1][OutWidth-1:0];
      out_data_o.nz         <= qx[2][OutWidth-1:0];
      out_data_o.degenerate <= dd_q[QW];
    end
  end

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.nx == '0 && out_data_o.ny == '0 && out_data_o.nz == '0)
    else $error("degenerate item with nonzero normal");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without an output stall");

  a_hold_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

endmodule
